// ===== rtl/ethdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ethdt_pkg
// Shared types and constants for the Ethernet type demultiplexing table.
// ----------------------------------------------------------------------------
package ethdt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_NOMATCH = 3'd1;
  localparam logic [2:0] STAT_INVALID = 3'd2;
  localparam logic [2:0] STAT_EXISTS  = 3'd3;
  localparam logic [2:0] STAT_FULL    = 3'd4;
  localparam logic [2:0] STAT_SKIPPED = 3'd5;

  // destination classes
  localparam logic [1:0] CLS_OWN     = 2'd0;
  localparam logic [1:0] CLS_BCAST   = 2'd1;
  localparam logic [1:0] CLS_MCAST   = 2'd2;
  localparam logic [1:0] CLS_FOREIGN = 2'd3;

  localparam logic [15:0] MIN_FRAME   = 16'd14;
  localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] OWN_MAC_RST = 48'h0200_0000_0000;
  localparam int          GROUP_BIT   = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_DONE
  } state_t;

  // request handed from the top level to the sequencer
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] eth_type;
    logic [31:0] proto_id;
    logic        desc_valid;
    logic        last_desc;
    logic        short_frame;
  } req_t;

  // finished result from the sequencer
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] proto;
  } res_t;

  // compare unit flags
  typedef struct packed {
    logic type_eq;
    logic proto_eq;
  } match_t;

endpackage

// ===== rtl/ethdt_match.sv =====
// ----------------------------------------------------------------------------
// ethdt_match
// Shared compare unit: one table entry against the request key.
// ----------------------------------------------------------------------------
module ethdt_match (
  input  logic [15:0]       entry_type,
  input  logic [31:0]       entry_proto,
  input  logic [15:0]       key_type,
  input  logic [31:0]       key_proto,
  output ethdt_pkg::match_t flags
);

  assign flags.type_eq  = (entry_type == key_type);
  assign flags.proto_eq = (entry_proto == key_proto);

endmodule

// ===== rtl/ethdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ethdt_ctrl
// Sequencer and table store; walks one entry per cycle through the
// shared compare unit.
// ----------------------------------------------------------------------------
module ethdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ethdt_pkg::req_t   req_in,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output ethdt_pkg::res_t   res
);

  ethdt_pkg::state_t state, state_next;
  ethdt_pkg::req_t   req, req_next;
  logic [ethdt_pkg::IDX_W-1:0] idx, idx_next;
  logic [ethdt_pkg::IDX_W-1:0] slot, slot_next;
  logic slot_found, slot_found_next;
  logic [2:0]  status, status_next;
  logic [31:0] pout, pout_next;
  logic aborted, aborted_next;
  logic [ethdt_pkg::TABLE_ENTRIES-1:0] used, used_next;

  logic [15:0] entry_type  [ethdt_pkg::TABLE_ENTRIES];
  logic [31:0] entry_proto [ethdt_pkg::TABLE_ENTRIES];

  logic        wr_en;
  logic [ethdt_pkg::IDX_W-1:0] wr_slot;
  logic [15:0] rd_type;
  logic [31:0] rd_proto;
  logic        rd_used;
  logic        last_idx;
  ethdt_pkg::match_t m;

  assign rd_type  = entry_type[idx];
  assign rd_proto = entry_proto[idx];
  assign rd_used  = used[idx];
  assign last_idx = (idx == ethdt_pkg::LAST_IDX);

  ethdt_match u_match (
    .entry_type (rd_type),
    .entry_proto(rd_proto),
    .key_type   (req.eth_type),
    .key_proto  (req.proto_id),
    .flags      (m)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ethdt_pkg::ST_IDLE;
      used    <= '0;
      aborted <= 1'b0;
    end else begin
      state   <= state_next;
      used    <= used_next;
      aborted <= aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    idx        <= idx_next;
    slot       <= slot_next;
    slot_found <= slot_found_next;
    status     <= status_next;
    pout       <= pout_next;
    if (wr_en) begin
      entry_type[wr_slot]  <= req.eth_type;
      entry_proto[wr_slot] <= req.proto_id;
    end
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    idx_next        = idx;
    slot_next       = slot;
    slot_found_next = slot_found;
    status_next     = status;
    pout_next       = pout;
    aborted_next    = aborted;
    used_next       = used;
    wr_en           = 1'b0;
    wr_slot         = slot_found ? slot : idx;
    res_valid       = 1'b0;

    case (state)
      ethdt_pkg::ST_IDLE: begin
        if (start) begin
          req_next        = req_in;
          idx_next        = '0;
          slot_found_next = 1'b0;
          pout_next       = '0;
          case (req_in.op)
            ethdt_pkg::OP_LOOKUP: begin
              if (req_in.short_frame) begin
                status_next = ethdt_pkg::STAT_NOMATCH;
                state_next  = ethdt_pkg::ST_DONE;
              end else begin
                state_next = ethdt_pkg::ST_SCAN;
              end
            end
            ethdt_pkg::OP_ADD: begin
              if (aborted) begin
                status_next = ethdt_pkg::STAT_SKIPPED;
                if (req_in.last_desc) aborted_next = 1'b0;
                state_next = ethdt_pkg::ST_DONE;
              end else if (!req_in.desc_valid) begin
                status_next = ethdt_pkg::STAT_INVALID;
                state_next  = ethdt_pkg::ST_FREE;
              end else begin
                state_next = ethdt_pkg::ST_SCAN;
              end
            end
            ethdt_pkg::OP_DELETE: begin
              status_next = ethdt_pkg::STAT_OK;
              state_next  = ethdt_pkg::ST_FREE;
            end
            default: begin
              status_next = ethdt_pkg::STAT_INVALID;
              state_next  = ethdt_pkg::ST_DONE;
            end
          endcase
        end
      end

      ethdt_pkg::ST_SCAN: begin
        if (req.op == ethdt_pkg::OP_LOOKUP) begin
          // first match wins
          if (rd_used && m.type_eq) begin
            status_next = ethdt_pkg::STAT_OK;
            pout_next   = rd_proto;
            state_next  = ethdt_pkg::ST_DONE;
          end else if (last_idx) begin
            status_next = ethdt_pkg::STAT_NOMATCH;
            state_next  = ethdt_pkg::ST_DONE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          if (rd_used && m.type_eq) begin
            if (m.proto_eq) begin
              status_next = ethdt_pkg::STAT_OK;
              state_next  = ethdt_pkg::ST_DONE;
            end else begin
              status_next = ethdt_pkg::STAT_EXISTS;
              idx_next    = '0;
              state_next  = ethdt_pkg::ST_FREE;
            end
          end else begin
            if (!rd_used && !slot_found) begin
              slot_next       = idx;
              slot_found_next = 1'b1;
            end
            if (last_idx) begin
              if (!slot_found && rd_used) begin
                status_next = ethdt_pkg::STAT_FULL;
                idx_next    = '0;
                state_next  = ethdt_pkg::ST_FREE;
              end else begin
                wr_en              = 1'b1;
                used_next[wr_slot] = 1'b1;
                status_next        = ethdt_pkg::STAT_OK;
                state_next         = ethdt_pkg::ST_DONE;
              end
            end else begin
              idx_next = idx + 1'b1;
            end
          end
        end
      end

      ethdt_pkg::ST_FREE: begin
        if (rd_used && m.proto_eq) used_next[idx] = 1'b0;
        if (last_idx) begin
          if (req.op == ethdt_pkg::OP_ADD) aborted_next = !req.last_desc;
          state_next = ethdt_pkg::ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      ethdt_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = ethdt_pkg::ST_IDLE;
      end

      default: begin
        state_next = ethdt_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle       = (state == ethdt_pkg::ST_IDLE);
  assign res.status = status;
  assign res.proto  = pout;

endmodule

// ===== rtl/ethdt_ctrl_unused_guard.sv =====
// ----------------------------------------------------------------------------
// ethdt_cls
// Destination MAC classifier: own unicast, broadcast, multicast or foreign.
// ----------------------------------------------------------------------------
module ethdt_cls (
  input  logic [47:0] mac,
  input  logic [47:0] own_mac,
  output logic [1:0]  cls
);

  always_comb begin
    if (mac[ethdt_pkg::GROUP_BIT]) begin
      cls = (mac == ethdt_pkg::BCAST_MAC) ? ethdt_pkg::CLS_BCAST : ethdt_pkg::CLS_MCAST;
    end else begin
      cls = (mac == own_mac) ? ethdt_pkg::CLS_OWN : ethdt_pkg::CLS_FOREIGN;
    end
  end

endmodule

// ===== rtl/ethertype_demux_table_top.sv =====
// ----------------------------------------------------------------------------
// ethertype_demux_table_top
// Ethernet type to protocol number table with lookup, add and delete.
// ----------------------------------------------------------------------------
// Request channel: in_valid / in_stall plus one port per field, taken on a
//   rising edge with in_valid high and in_stall low. in_stall is high in
//   reset and while the sequencer works on the previous request.
// Result channel: out_valid / out_stall plus status, dest_class, proto_out,
//   taken with out_valid high and out_stall low; a stalled result holds
//   steady in the output register. Config: cfg_we loads cfg_wdata into own_mac.
// Timing: one compare unit steps through the table, one entry per cycle.
//   Lookup scans 1 to 8 entries (stops at first hit); add scans up to 8 and
//   on failure makes a second pass of 8 to free the protocol; delete is one
//   pass. Short frames, skipped descriptors and unknown ops skip the scan and
//   go straight to the result; a new request is taken only once the previous
//   result has moved into the output register.
// A stalled receiver holds the request side off once a second result is ready.
// Reset: rst (synchronous) empties the table, clears the aborted-group flag
//   and loads own_mac with 02:00:00:00:00:00.
// ----------------------------------------------------------------------------
module ethertype_demux_table_top (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [47:0] dest_mac,
  input  logic [15:0] eth_type,
  input  logic [15:0] frame_length,
  input  logic [31:0] proto_id,
  input  logic        desc_valid,
  input  logic        last_desc,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  dest_class,
  output logic [31:0] proto_out
);

  logic [47:0] own_mac;
  logic        idle;
  logic        start;
  logic        res_valid;
  logic        res_ready;
  logic [1:0]  cls_raw;
  logic [1:0]  cls;       // class held for the request in flight
  logic        short_frame;
  ethdt_pkg::req_t req;
  ethdt_pkg::res_t res;

  // station address register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= ethdt_pkg::OWN_MAC_RST;
    end else if (cfg_we) begin
      own_mac <= cfg_wdata;
    end
  end

  assign in_stall    = rst || !idle;
  assign start       = in_valid && !in_stall;
  assign short_frame = (frame_length < ethdt_pkg::MIN_FRAME);

  // classify at acceptance; the user must see that own_mac only changes while idle; the block does not enforce it
  ethdt_cls u_cls (
    .mac    (dest_mac),
    .own_mac(own_mac),
    .cls    (cls_raw)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      cls <= (op == ethdt_pkg::OP_LOOKUP && !short_frame) ? cls_raw
                                                          : ethdt_pkg::CLS_OWN;
    end
  end

  assign req.op          = op;
  assign req.eth_type    = eth_type;
  assign req.proto_id    = proto_id;
  assign req.desc_valid  = desc_valid;
  assign req.last_desc   = last_desc;
  assign req.short_frame = short_frame;

  ethdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_in   (req),
    .idle     (idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register; loads when empty or being drained this cycle
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status     <= res.status;
      dest_class <= cls;
      proto_out  <= res.proto;
    end
  end

endmodule

// ===== sim/ethertype_demux_table_top_test.sv =====
// ----------------------------------------------------------------------------
// ethertype_demux_table_top_test
// Self-checking bench for the Ethernet type demultiplexing table. Requests
// go in with random bursts and gaps while the result side stalls on its own
// pattern. Every accepted request runs through a local model of the table,
// and each result is checked field by field against the oldest prediction.
// Directed checks cover short frames, conflicts, aborted groups and a full
// table. Random traffic then runs under several station MAC settings.
// ----------------------------------------------------------------------------
module ethertype_demux_table_top_test;

  // the package stops at delete; the block reports invalid for the spare code
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         SHOWN_MAX   = 10;
  localparam int         PHASE_REQS  = 160;

  // one request as it goes into the table
  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] mac;
    logic [15:0] etype;
    logic [15:0] flen;
    logic [31:0] proto;
    logic        valid;
    logic        last;
  } demux_req_t;

  // one result as it comes back
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  cls;
    logic [31:0] proto;
  } demux_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [47:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = ethdt_pkg::OP_LOOKUP;
  logic [47:0] dest_mac = '0;
  logic [15:0] eth_type = '0;
  logic [15:0] frame_length = '0;
  logic [31:0] proto_id = '0;
  logic        desc_valid = 1'b0;
  logic        last_desc = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [1:0]  dest_class;
  logic [31:0] proto_out;

  ethertype_demux_table_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .dest_mac     (dest_mac),
    .eth_type     (eth_type),
    .frame_length (frame_length),
    .proto_id     (proto_id),
    .desc_valid   (desc_valid),
    .last_desc    (last_desc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .dest_class   (dest_class),
    .proto_out    (proto_out)
  );

  // 10 unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the table. Type and protocol of an entry are only looked
  // at while its used flag is set, so they need no reset value.
  // --------------------------------------------------------------------------
  logic        tbl_used [ethdt_pkg::TABLE_ENTRIES] = '{default: 1'b0};
  logic [15:0] tbl_type [ethdt_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_proto [ethdt_pkg::TABLE_ENTRIES];
  logic        group_skip = 1'b0;
  logic [47:0] station_mac = ethdt_pkg::OWN_MAC_RST;

  demux_res_t  pending_q[$];   // predicted results, oldest first
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  // free every entry bound to a protocol
  function automatic void drop_protocol(input logic [31:0] p);
    for (int i = 0; i < ethdt_pkg::TABLE_ENTRIES; i++)
      if (tbl_used[i] && tbl_proto[i] == p) tbl_used[i] = 1'b0;
  endfunction

  // apply one request to the local table and return what the block must say
  function automatic demux_res_t table_outcome(input demux_req_t r);
    demux_res_t res;
    int         slot;
    logic       hit;
    res  = '{status: ethdt_pkg::STAT_INVALID, cls: ethdt_pkg::CLS_OWN, proto: '0};
    slot = -1;
    hit  = 1'b0;
    case (r.op)
      ethdt_pkg::OP_LOOKUP: begin
        res.status = ethdt_pkg::STAT_NOMATCH;
        // runt frames report the own class and no match
        if (r.flen >= ethdt_pkg::MIN_FRAME) begin
          if (r.mac[ethdt_pkg::GROUP_BIT])
            res.cls = (r.mac == ethdt_pkg::BCAST_MAC) ? ethdt_pkg::CLS_BCAST
                                                      : ethdt_pkg::CLS_MCAST;
          else
            res.cls = (r.mac == station_mac) ? ethdt_pkg::CLS_OWN
                                             : ethdt_pkg::CLS_FOREIGN;
          // first used entry with the type wins
          for (int i = 0; i < ethdt_pkg::TABLE_ENTRIES; i++) begin
            if (!hit && tbl_used[i] && tbl_type[i] == r.etype) begin
              hit        = 1'b1;
              res.status = ethdt_pkg::STAT_OK;
              res.proto  = tbl_proto[i];
            end
          end
        end
      end
      ethdt_pkg::OP_ADD: begin
        if (group_skip) begin
          // rest of a failed group; its last descriptor ends the skip
          res.status = ethdt_pkg::STAT_SKIPPED;
          if (r.last) group_skip = 1'b0;
        end else begin
          if (!r.valid) begin
            res.status = ethdt_pkg::STAT_INVALID;
          end else begin
            for (int i = 0; i < ethdt_pkg::TABLE_ENTRIES; i++) begin
              if (!hit) begin
                if (tbl_used[i]) begin
                  if (tbl_type[i] == r.etype) begin
                    hit        = 1'b1;
                    res.status = (tbl_proto[i] == r.proto) ? ethdt_pkg::STAT_OK
                                                           : ethdt_pkg::STAT_EXISTS;
                  end
                end else if (slot < 0) begin
                  slot = i;
                end
              end
            end
            if (!hit) begin
              if (slot < 0) begin
                res.status = ethdt_pkg::STAT_FULL;
              end else begin
                tbl_used[slot]  = 1'b1;
                tbl_type[slot]  = r.etype;
                tbl_proto[slot] = r.proto;
                res.status      = ethdt_pkg::STAT_OK;
              end
            end
          end
          // a failed add takes the whole protocol out again
          if (res.status != ethdt_pkg::STAT_OK) begin
            drop_protocol(r.proto);
            group_skip = !r.last;
          end
        end
      end
      ethdt_pkg::OP_DELETE: begin
        drop_protocol(r.proto);
        res.status = ethdt_pkg::STAT_OK;
      end
      default: ;   // spare op: invalid, nothing changes
    endcase
    return res;
  endfunction

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom(), $urandom()});
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Requests go out in bursts; valid drops only between bursts,
  // and a long burst now and then gives stretches with no gaps at all.
  // --------------------------------------------------------------------------
  task automatic issue_request(input logic [1:0] r_op, input logic [47:0] r_mac,
                               input logic [15:0] r_type, input logic [15:0] r_len,
                               input logic [31:0] r_proto, input logic r_valid,
                               input logic r_last);
    demux_req_t r;
    r = '{op: r_op, mac: r_mac, etype: r_type, flen: r_len, proto: r_proto,
          valid: r_valid, last: r_last};
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    op           <= r.op;
    dest_mac     <= r.mac;
    eth_type     <= r.etype;
    frame_length <= r.flen;
    proto_id     <= r.proto;
    desc_valid   <= r.valid;
    last_desc    <= r.last;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_q.push_back(table_outcome(r));
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_idle();
    if (burst_left != 0) begin
      burst_left = 0;
      in_valid <= 1'b0;
    end
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // own_mac is only written with nothing in flight
  task automatic write_station_mac(input logic [47:0] mac);
    cfg_wdata <= mac;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    station_mac = mac;
  endtask

  // --------------------------------------------------------------------------
  // Result side. The stall pattern switches between free flow, light and
  // heavy random stalls, and a fixed long-stall rhythm.
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((cycle_count % 16) < 11);
    endcase
  end

  demux_res_t want_res;

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("result %0d arrived with none pending: status %0d class %0d proto %h",
                   results_seen, status, dest_class, proto_out);
      end else begin
        want_res = pending_q.pop_front();
        if (status !== want_res.status || dest_class !== want_res.cls ||
            proto_out !== want_res.proto) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("result %0d: status %0d/%0d class %0d/%0d proto %h/%h (want/got)",
                     results_seen, want_res.status, status, want_res.cls, dest_class,
                     want_res.proto, proto_out);
        end
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ethertype_demux_table_top: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // runts and the first valid length on an empty table
  task automatic test_short_frames();
    issue_request(ethdt_pkg::OP_LOOKUP, ethdt_pkg::BCAST_MAC, 16'h0800, 16'd0, '0,
                  1'b0, 1'b0);
    issue_request(ethdt_pkg::OP_LOOKUP, ethdt_pkg::OWN_MAC_RST, 16'h0800, 16'd13, '0,
                  1'b0, 1'b0);
    issue_request(ethdt_pkg::OP_LOOKUP, ethdt_pkg::OWN_MAC_RST, 16'h0800,
                  ethdt_pkg::MIN_FRAME, '0, 1'b0, 1'b0);
  endtask

  // repeat add, conflicting protocol, skipped group, invalid descriptor
  task automatic test_add_conflict();
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h0800, '0, 32'd1, 1'b1, 1'b0);
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h0800, '0, 32'd1, 1'b1, 1'b1);
    issue_request(ethdt_pkg::OP_ADD, '0, 16'hFFFF, '0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue_request(ethdt_pkg::OP_LOOKUP, ethdt_pkg::BCAST_MAC, 16'h0800, 16'hFFFF, '0,
                  1'b0, 1'b0);
    issue_request(ethdt_pkg::OP_LOOKUP, 48'h0100_5E00_0001, 16'hFFFF, 16'd64, '0,
                  1'b0, 1'b0);
    // type held by protocol 1: fails and the group of protocol 2 is skipped
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h0800, '0, 32'd2, 1'b1, 1'b0);
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h86DD, '0, 32'd2, 1'b1, 1'b0);
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h86DD, '0, 32'd2, 1'b1, 1'b1);
    // bad descriptor frees protocol 1; last set, so no skip follows
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h0806, '0, 32'd1, 1'b0, 1'b1);
    issue_request(ethdt_pkg::OP_LOOKUP, 48'h0, 16'h0800, 16'd60, '0, 1'b0, 1'b0);
    issue_request(ethdt_pkg::OP_DELETE, '0, '0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0);
  endtask

  // fill all entries, then overflow
  task automatic test_table_full();
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h0000, '0, 32'd0, 1'b1, 1'b1);
    for (int i = 1; i < ethdt_pkg::TABLE_ENTRIES; i++)
      issue_request(ethdt_pkg::OP_ADD, '0, 16'h0100 + 16'(i), '0, 32'd7, 1'b1,
                    i == ethdt_pkg::TABLE_ENTRIES - 1);
    // no room: every entry of protocol 7 goes, protocol 0 stays
    issue_request(ethdt_pkg::OP_ADD, '0, 16'h0200, '0, 32'd7, 1'b1, 1'b1);
    issue_request(ethdt_pkg::OP_LOOKUP, ethdt_pkg::OWN_MAC_RST, 16'h0000, 16'd14, '0,
                  1'b0, 1'b0);
    issue_request(ethdt_pkg::OP_LOOKUP, ethdt_pkg::OWN_MAC_RST, 16'h0101, 16'd14, '0,
                  1'b0, 1'b0);
  endtask

  task automatic test_reserved_op();
    issue_request(OP_RESERVED, rand_mac(), 16'h0000, 16'd64, 32'd0, 1'b1, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic under one station MAC. Types and protocols come mostly
  // from small pools so that hits, conflicts and a full table all occur.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input logic [47:0] mac, input int n_reqs);
    logic [15:0] type_pool [10];
    logic [31:0] proto_pool [4];
    logic [47:0] m;
    logic [15:0] len;
    logic [31:0] p;
    int          sent;
    int          glen;
    int          pick;

    wait_idle();
    write_station_mac(mac);
    type_pool = '{16'h0800, 16'h86DD, 16'h0000, 16'hFFFF, 16'h0806,
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom)};
    foreach (proto_pool[i]) begin
      pick = $urandom_range(0, 5);
      proto_pool[i] = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
    end
    sent = 0;
    while (sent < n_reqs) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 5))
          0:       m = station_mac;
          1:       m = ethdt_pkg::BCAST_MAC;
          2:       m = rand_mac() | (48'h1 << ethdt_pkg::GROUP_BIT);
          3:       m = rand_mac() & ~(48'h1 << ethdt_pkg::GROUP_BIT);
          4:       m = station_mac ^ (48'h1 << $urandom_range(0, 47));
          default: m = rand_mac();
        endcase
        case ($urandom_range(0, 9))
          0:       len = 16'($urandom_range(0, 13));
          1:       len = 16'($urandom_range(14, 15));
          2:       len = 16'($urandom);
          default: len = 16'($urandom_range(60, 1514));
        endcase
        issue_request(ethdt_pkg::OP_LOOKUP, m, type_pool[$urandom_range(0, 9)], len,
                      $urandom, 1'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 80) begin
        // well-formed group of one protocol, with a stray lookup now and then
        glen = $urandom_range(1, 4);
        p    = proto_pool[$urandom_range(0, 3)];
        for (int k = 0; k < glen; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            issue_request(ethdt_pkg::OP_LOOKUP, rand_mac(),
                          type_pool[$urandom_range(0, 9)], 16'd64, '0, 1'b0, 1'b0);
            sent++;
          end
          issue_request(ethdt_pkg::OP_ADD, rand_mac(), type_pool[$urandom_range(0, 9)],
                        16'($urandom), p, $urandom_range(0, 15) != 0, k == glen - 1);
          sent++;
        end
      end else if (pick < 95) begin
        p = ($urandom_range(0, 7) == 0) ? $urandom : proto_pool[$urandom_range(0, 3)];
        issue_request(ethdt_pkg::OP_DELETE, rand_mac(), 16'($urandom), 16'($urandom), p,
                      1'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 98) begin
        // loose descriptor, often leaves a group open
        issue_request(ethdt_pkg::OP_ADD, rand_mac(), 16'($urandom), 16'($urandom),
                      $urandom, 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        issue_request(OP_RESERVED, rand_mac(), 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_frames();
    test_add_conflict();
    test_table_full();
    test_reserved_op();

    test_random_traffic(48'h0000_0000_0000, PHASE_REQS);
    test_random_traffic(48'hFFFF_FFFF_FFFF, PHASE_REQS);
    test_random_traffic(rand_mac() & ~(48'h1 << ethdt_pkg::GROUP_BIT), PHASE_REQS);
    test_random_traffic(ethdt_pkg::OWN_MAC_RST, PHASE_REQS);
    test_random_traffic(rand_mac(), PHASE_REQS);

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("ethertype_demux_table_top: match");
    else
      $display("ethertype_demux_table_top: mismatch");
    $finish;
  end

endmodule

// ===== ethertype_demux_table_top.f =====
rtl/ethdt_pkg.sv
rtl/ethdt_match.sv
rtl/ethdt_ctrl.sv
rtl/ethdt_ctrl_unused_guard.sv
rtl/ethertype_demux_table_top.sv
sim/ethertype_demux_table_top_test.sv
